[sv/ffqs_pkg.sv]
// ----------------------------------------------------------------------------
// ffqs_pkg
// Shared types and field widths for the searchable FIFO queue.
// ----------------------------------------------------------------------------
package ffqs_pkg;

    localparam int CMD_W    = 3;
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 7;
    localparam int STATUS_W = 2;
    localparam int DATA_W   = 32;
    localparam int COUNT_W  = 7;

    // Request item: command, value, position, padded to whole bytes.
    localparam int IN_BITS  = CMD_W + VALUE_W + POS_W;
    localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;

    // Result item: status, data, found position, count, padded to whole bytes.
    localparam int OUT_BITS = STATUS_W + DATA_W + POS_W + COUNT_W;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_RESTART  = 3'd0,
        CMD_PUSH     = 3'd1,
        CMD_POP      = 3'd2,
        CMD_FIND_POS = 3'd3,
        CMD_FIND_VAL = 3'd4,
        CMD_CLEAR    = 3'd5
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK        = 2'd0,
        STATUS_EMPTY     = 2'd1,
        STATUS_FULL      = 2'd2,
        STATUS_NOT_FOUND = 2'd3
    } status_t;

endpackage

[sv/ffqs_ram.sv]
// ----------------------------------------------------------------------------
// ffqs_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module ffqs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                 clk,
    input  logic                                 we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                     wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[sv/fifo_queue_with_search_top.sv]
// ----------------------------------------------------------------------------
// fifo_queue_with_search_top
// Bounded FIFO of words kept as a ring in one RAM, with push, pop, clear,
// restart, lookup by position and linear search by value.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Payload (low bits first)
//  -------   ---------  -----------------------------------------------------
//  s_axis    in         command[2:0], value[34:3], position[41:35], pad to 48
//  m_axis    out        status[1:0], data[33:2], found_position[40:34],
//                       count[47:41]
//
// One request is processed at a time. Restart, push, clear and unused codes
// go from EXEC straight to RESULT; pop and lookup by position pass through
// READ, where they wait for the RAM read. Search by value reads one stored
// word per cycle in SCAN, at most the whole count, because there is a single
// RAM read port. The input is ready again when the result is loaded into the
// output register, so a new request is only taken once the last is through.
// A new request is accepted while a finished result still sits in the output
// register; a result only waits when that register is still occupied.
// Reset clears the pointers and the count at once; the RAM needs no clearing
// pass because only entries inside the count are ever read.
// ----------------------------------------------------------------------------
module fifo_queue_with_search_top #(
    parameter int DEPTH      = 64,
    parameter int WORD_WIDTH = 32
) (
    input  logic                       clk,
    input  logic                       rst_n,

    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    // command[2:0], value[34:3], position[41:35], zero pad above
    input  logic [ffqs_pkg::IN_W-1:0]  s_axis_tdata,

    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    // status[1:0], data[33:2], found_position[40:34], count[47:41]
    output logic [ffqs_pkg::OUT_W-1:0] m_axis_tdata
);

    // Address width of the ring, width of the fill count (holds DEPTH itself).
    localparam int AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW  = $clog2(DEPTH + 1);
    // Common width for comparing the 7-bit position against the count.
    localparam int PCW = (CW > ffqs_pkg::POS_W) ? CW : ffqs_pkg::POS_W;
    // Common width for moving words between the 32-bit fields and the store.
    localparam int XW  = (WORD_WIDTH > ffqs_pkg::DATA_W) ? WORD_WIDTH : ffqs_pkg::DATA_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_READ,
        ST_SCAN,
        ST_RESULT
    } state_t;

    // Value field into a stored word: zero extend or keep the low WORD_WIDTH bits.
    function automatic logic [WORD_WIDTH-1:0] value_to_word(
        input logic [ffqs_pkg::VALUE_W-1:0] v
    );
        logic [XW-1:0] wide;
        wide = XW'(v);
        return wide[WORD_WIDTH-1:0];
    endfunction

    // Stored word into the data field: zero extend or keep the low bits.
    function automatic logic [ffqs_pkg::DATA_W-1:0] word_to_data(
        input logic [WORD_WIDTH-1:0] w
    );
        logic [XW-1:0] wide;
        wide = XW'(w);
        return wide[ffqs_pkg::DATA_W-1:0];
    endfunction

    function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] i);
        return (i == AW'(DEPTH - 1)) ? '0 : i + AW'(1);
    endfunction

    // Control state
    state_t                        state_reg,     state_next;
    logic [AW-1:0]                 head_reg,      head_next;
    logic [AW-1:0]                 tail_reg,      tail_next;
    logic [CW-1:0]                 fill_reg,      fill_next;
    logic                          out_valid_reg, out_valid_next;

    // Request, search progress and result payload
    ffqs_pkg::cmd_t                req_cmd_reg,   req_cmd_next;
    logic [WORD_WIDTH-1:0]         req_word_reg,  req_word_next;
    logic [ffqs_pkg::POS_W-1:0]    req_pos_reg,   req_pos_next;
    logic [AW-1:0]                 scan_idx_reg,  scan_idx_next;
    logic [AW-1:0]                 cmp_cnt_reg,   cmp_cnt_next;
    ffqs_pkg::status_t             res_status_reg, res_status_next;
    logic [ffqs_pkg::DATA_W-1:0]   res_data_reg,  res_data_next;
    logic [ffqs_pkg::POS_W-1:0]    res_fpos_reg,  res_fpos_next;
    logic [ffqs_pkg::OUT_W-1:0]    out_tdata_reg, out_tdata_next;

    // RAM ports
    logic                          ram_we;
    logic [AW-1:0]                 ram_waddr;
    logic [WORD_WIDTH-1:0]         ram_wdata;
    logic [AW-1:0]                 ram_raddr;
    logic [WORD_WIDTH-1:0]         ram_rdata;

    // Address arithmetic for lookup by position and search bookkeeping.
    logic [PCW-1:0]                pos_wide;
    logic [PCW-1:0]                fill_wide;
    logic [PCW-1:0]                pos_m1;
    logic [AW:0]                   pos_sum;
    logic [AW-1:0]                 pos_addr;
    logic                          pos_bad;
    logic [PCW-1:0]                cmp_wide;
    logic [PCW-1:0]                fpos_wide;
    logic [PCW-1:0]                count_wide;

    assign pos_wide   = PCW'(req_pos_reg);
    assign fill_wide  = PCW'(fill_reg);
    assign pos_m1     = pos_wide - PCW'(1);
    assign pos_bad    = (pos_wide == '0) || (pos_wide > fill_wide);
    // Head plus an offset below DEPTH stays under twice DEPTH: one subtract wraps it.
    assign pos_sum    = {1'b0, head_reg} + {1'b0, pos_m1[AW-1:0]};
    assign pos_addr   = (pos_sum >= (AW+1)'(DEPTH)) ? AW'(pos_sum - (AW+1)'(DEPTH))
                                                    : pos_sum[AW-1:0];
    assign cmp_wide   = PCW'(cmp_cnt_reg);
    assign fpos_wide  = cmp_wide + PCW'(1);
    assign count_wide = PCW'(fill_reg);

    ffqs_ram #(
        .WIDTH (WORD_WIDTH),
        .DEPTH (DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_tdata_reg;

    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        fill_next       = fill_reg;
        out_valid_next  = out_valid_reg;
        req_cmd_next    = req_cmd_reg;
        req_word_next   = req_word_reg;
        req_pos_next    = req_pos_reg;
        scan_idx_next   = scan_idx_reg;
        cmp_cnt_next    = cmp_cnt_reg;
        res_status_next = res_status_reg;
        res_data_next   = res_data_reg;
        res_fpos_next   = res_fpos_reg;
        out_tdata_next  = out_tdata_reg;

        ram_we    = 1'b0;
        ram_waddr = tail_reg;
        ram_wdata = req_word_reg;
        ram_raddr = head_reg;

        // The downstream side took the waiting result.
        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    req_cmd_next  = ffqs_pkg::cmd_t'(s_axis_tdata[2:0]);
                    req_word_next = value_to_word(s_axis_tdata[34:3]);
                    req_pos_next  = s_axis_tdata[41:35];
                    state_next    = ST_EXEC;
                end
            end

            ST_EXEC:
            begin
                res_status_next = ffqs_pkg::STATUS_OK;
                res_data_next   = '0;
                res_fpos_next   = '0;
                state_next      = ST_RESULT;
                unique case (req_cmd_reg)
                    ffqs_pkg::CMD_RESTART:
                    begin
                        // Empty the ring, then the word lands in entry zero.
                        ram_we    = 1'b1;
                        ram_waddr = '0;
                        head_next = '0;
                        tail_next = AW'(1);
                        fill_next = CW'(1);
                    end
                    ffqs_pkg::CMD_PUSH:
                    begin
                        if (fill_reg == CW'(DEPTH))
                        begin
                            res_status_next = ffqs_pkg::STATUS_FULL;
                        end
                        else
                        begin
                            ram_we    = 1'b1;
                            tail_next = ring_inc(tail_reg);
                            fill_next = fill_reg + CW'(1);
                        end
                    end
                    ffqs_pkg::CMD_POP:
                    begin
                        if (fill_reg == '0)
                        begin
                            res_status_next = ffqs_pkg::STATUS_EMPTY;
                        end
                        else
                        begin
                            ram_raddr  = head_reg;
                            state_next = ST_READ;
                        end
                    end
                    ffqs_pkg::CMD_FIND_POS:
                    begin
                        if (fill_reg == '0)
                        begin
                            res_status_next = ffqs_pkg::STATUS_EMPTY;
                        end
                        else if (pos_bad)
                        begin
                            res_status_next = ffqs_pkg::STATUS_NOT_FOUND;
                        end
                        else
                        begin
                            ram_raddr  = pos_addr;
                            state_next = ST_READ;
                        end
                    end
                    ffqs_pkg::CMD_FIND_VAL:
                    begin
                        if (fill_reg == '0)
                        begin
                            res_status_next = ffqs_pkg::STATUS_EMPTY;
                        end
                        else
                        begin
                            // The head word is read now; the next address is queued.
                            ram_raddr     = head_reg;
                            scan_idx_next = ring_inc(head_reg);
                            cmp_cnt_next  = '0;
                            state_next    = ST_SCAN;
                        end
                    end
                    ffqs_pkg::CMD_CLEAR:
                    begin
                        if (fill_reg == '0)
                        begin
                            res_status_next = ffqs_pkg::STATUS_EMPTY;
                        end
                        head_next = '0;
                        tail_next = '0;
                        fill_next = '0;
                    end
                    default:
                    begin
                    end
                endcase
            end

            ST_READ:
            begin
                res_data_next = word_to_data(ram_rdata);
                state_next    = ST_RESULT;
                if (req_cmd_reg == ffqs_pkg::CMD_POP)
                begin
                    fill_next = fill_reg - CW'(1);
                    // Taking the last word returns both pointers to zero.
                    if (fill_reg == CW'(1))
                    begin
                        head_next = '0;
                        tail_next = '0;
                    end
                    else
                    begin
                        head_next = ring_inc(head_reg);
                    end
                end
            end

            ST_SCAN:
            begin
                if (ram_rdata == req_word_reg)
                begin
                    res_status_next = ffqs_pkg::STATUS_OK;
                    res_data_next   = word_to_data(req_word_reg);
                    res_fpos_next   = fpos_wide[ffqs_pkg::POS_W-1:0];
                    state_next      = ST_RESULT;
                end
                else if (cmp_wide == fill_wide - PCW'(1))
                begin
                    res_status_next = ffqs_pkg::STATUS_NOT_FOUND;
                    state_next      = ST_RESULT;
                end
                else
                begin
                    ram_raddr     = scan_idx_reg;
                    scan_idx_next = ring_inc(scan_idx_reg);
                    cmp_cnt_next  = cmp_cnt_reg + AW'(1);
                end
            end

            ST_RESULT:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_tdata_next = ffqs_pkg::OUT_W'({count_wide[ffqs_pkg::COUNT_W-1:0],
                                                       res_fpos_reg,
                                                       res_data_reg,
                                                       res_status_reg});
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_cmd_reg    <= req_cmd_next;
        req_word_reg   <= req_word_next;
        req_pos_reg    <= req_pos_next;
        scan_idx_reg   <= scan_idx_next;
        cmp_cnt_reg    <= cmp_cnt_next;
        res_status_reg <= res_status_next;
        res_data_reg   <= res_data_next;
        res_fpos_reg   <= res_fpos_next;
        out_tdata_reg  <= out_tdata_next;
    end

endmodule
